// ===== rtl/cbsf_pkg.sv =====
// ----------------------------------------------------------------------------
// cbsf_pkg
// Shared types, constants and the byte-wide CRC-32 step for the framer.
// ----------------------------------------------------------------------------
package cbsf_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [31:0] CRC_POLY_REFL = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES      = 32'hFFFF_FFFF;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEADER_BYTE   = 3'd0,
    REG_LEADER_LENGTH = 3'd1,
    REG_ESCAPE_BYTE   = 3'd2,
    REG_CRC_ENABLE    = 3'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_DATA,
    PH_LEAD,
    PH_CRC,
    PH_ESC
  } phase_t;

  // queue entry between front and back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       first;
  } q_entry_t;

  // active configuration, leader length already clamped to 2..8
  typedef struct packed {
    logic [7:0] leader_byte;
    logic [3:0] lead_len;
    logic [7:0] escape_byte;
    logic       crc_en;
  } cfg_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/crc32_byte_stuffing_framer_core.sv =====
// ----------------------------------------------------------------------------
// crc32_byte_stuffing_framer_core
// Byte-stuffing framer with leader, escape insertion and appended CRC-32.
//
//   channel  handshake              payload
//   input    push / full            in_byte[7:0], last
//   result   pop / empty            out_byte[7:0], end_of_frame
//   config   cfg_valid / cfg_ready  cfg_index[2:0], cfg_data[7:0]
//
// One output word per cycle while the receiver pops; each input byte yields its
// data word plus every inserted leader, escape or CRC word, set by the single
// back-end sequencer. A 4-deep queue lets input keep flowing while the back end
// inserts words. An accepted byte is queued, then its first word is registered.
// rst is synchronous and restores register defaults; cfg_ready is always high.
// ----------------------------------------------------------------------------
module crc32_byte_stuffing_framer_core import cbsf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           in_byte,
  input  logic                 last,
  output logic                 empty,
  input  logic                 pop,
  output logic [7:0]           out_byte,
  output logic                 end_of_frame,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic [7:0] leader_byte;
  logic [3:0] leader_length;
  logic [7:0] escape_byte;
  logic       crc_enable;
  cfg_t       cfg;
  logic       q_valid;
  q_entry_t   q_head;
  logic       q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      leader_byte   <= 8'd60;
      leader_length <= 4'd4;
      escape_byte   <= 8'd195;
      crc_enable    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LEADER_BYTE:   leader_byte   <= cfg_data;
        REG_LEADER_LENGTH: leader_length <= cfg_data[3:0];
        REG_ESCAPE_BYTE:   escape_byte   <= cfg_data;
        REG_CRC_ENABLE:    crc_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.leader_byte = leader_byte;
    cfg.escape_byte = escape_byte;
    cfg.crc_en      = crc_enable;
    if (leader_length < 4'd2) begin
      cfg.lead_len = 4'd2;
    end else if (leader_length > 4'd8) begin
      cfg.lead_len = 4'd8;
    end else begin
      cfg.lead_len = leader_length;
    end
  end

  cbsf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_byte (in_byte),
    .last    (last),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  cbsf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .end_of_frame (end_of_frame)
  );

endmodule

// ===== rtl/cbsf_front.sv =====
// ----------------------------------------------------------------------------
// cbsf_front
// Accepts packet bytes, tags the first byte of each packet and queues them.
// ----------------------------------------------------------------------------
module cbsf_front import cbsf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       last,
  output logic       q_valid,
  output q_entry_t   q_head,
  input  logic       q_pop
);

  q_entry_t       mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           in_pkt;
  logic           acc;

  assign full    = (count == (QAW+1)'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_head  = mem[rd_ptr];
  assign acc     = push && !full;

  always_ff @(posedge clk) begin
    if (acc) begin
      mem[wr_ptr] <= '{data: in_byte, last: last, first: !in_pkt};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      in_pkt <= 1'b0;
    end else begin
      if (acc) begin
        wr_ptr <= wr_ptr + 1'b1;
        in_pkt <= !last;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({acc, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/cbsf_back.sv =====
// ----------------------------------------------------------------------------
// cbsf_back
// Frame sequencer: leader, stuffed data, escape and CRC bytes, output word.
// ----------------------------------------------------------------------------
module cbsf_back import cbsf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  q_entry_t   q_head,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       end_of_frame
);

  phase_t      phase, phase_next;
  logic [3:0]  lead_cnt, lead_cnt_next;
  logic        lead_done, lead_done_next;
  logic [2:0]  leader_run, leader_run_next;
  logic [31:0] crc_reg, crc_reg_next;
  logic [1:0]  crc_idx, crc_idx_next;
  logic        esc_crc, esc_crc_next;
  logic        esc_end, esc_end_next;
  logic        ovalid;

  logic        adv, fire;
  logic        emit_v, emit_eof, pop_sel;
  logic [7:0]  emit_b;
  logic [7:0]  stuff_in;
  logic [7:0]  crc_b;
  logic [31:0] crc_fin;
  logic [2:0]  run_new;
  logic [2:0]  thresh;
  logic        esc;

  assign adv     = !ovalid || pop;
  assign fire    = adv && emit_v;
  assign q_pop   = fire && pop_sel;
  assign empty   = !ovalid;
  assign thresh  = 3'(cfg.lead_len - 4'd1);
  assign crc_fin = ~crc_reg;

  always_comb begin
    unique case (crc_idx)
      2'd0: crc_b = crc_fin[31:24];
      2'd1: crc_b = crc_fin[23:16];
      2'd2: crc_b = crc_fin[15:8];
      2'd3: crc_b = crc_fin[7:0];
    endcase
  end

  assign stuff_in = (phase == PH_CRC) ? crc_b : q_head.data;
  assign run_new  = (stuff_in == cfg.leader_byte) ? leader_run + 3'd1 : 3'd0;
  assign esc      = (run_new == thresh);

  always_comb begin
    phase_next      = phase;
    lead_cnt_next   = lead_cnt;
    lead_done_next  = lead_done;
    leader_run_next = leader_run;
    crc_reg_next    = crc_reg;
    crc_idx_next    = crc_idx;
    esc_crc_next    = esc_crc;
    esc_end_next    = esc_end;
    emit_v          = 1'b0;
    emit_b          = cfg.leader_byte;
    emit_eof        = 1'b0;
    pop_sel         = 1'b0;
    unique case (phase)
      PH_DATA: begin
        if (q_valid) begin
          emit_v = 1'b1;
          if (q_head.first && !lead_done) begin
            lead_cnt_next = 4'd1;
            phase_next    = PH_LEAD;
          end else begin
            emit_b          = q_head.data;
            pop_sel         = 1'b1;
            lead_done_next  = 1'b0;
            crc_reg_next    = crc32_byte(crc_reg, q_head.data);
            crc_idx_next    = 2'd0;
            leader_run_next = esc ? 3'd0 : run_new;
            if (esc) begin
              phase_next   = PH_ESC;
              esc_crc_next = q_head.last && cfg.crc_en;
              esc_end_next = q_head.last && !cfg.crc_en;
            end else if (q_head.last && cfg.crc_en) begin
              phase_next = PH_CRC;
            end else if (q_head.last) begin
              emit_eof        = 1'b1;
              leader_run_next = 3'd0;
              crc_reg_next    = CRC_ONES;
            end
          end
        end
      end
      PH_LEAD: begin
        emit_v        = 1'b1;
        lead_cnt_next = lead_cnt + 4'd1;
        if (lead_cnt + 4'd1 == cfg.lead_len) begin
          phase_next     = PH_DATA;
          lead_done_next = 1'b1;
        end
      end
      PH_CRC: begin
        emit_v          = 1'b1;
        emit_b          = crc_b;
        crc_idx_next    = crc_idx + 2'd1;
        leader_run_next = esc ? 3'd0 : run_new;
        if (esc) begin
          phase_next   = PH_ESC;
          esc_crc_next = (crc_idx != 2'd3);
          esc_end_next = (crc_idx == 2'd3);
          if (crc_idx == 2'd3) begin
            crc_reg_next = CRC_ONES;
          end
        end else if (crc_idx == 2'd3) begin
          emit_eof        = 1'b1;
          leader_run_next = 3'd0;
          crc_reg_next    = CRC_ONES;
          phase_next      = PH_DATA;
        end
      end
      PH_ESC: begin
        emit_v          = 1'b1;
        emit_b          = cfg.escape_byte;
        emit_eof        = esc_end;
        leader_run_next = 3'd0;
        phase_next      = esc_crc ? PH_CRC : PH_DATA;
        if (esc_end) begin
          crc_reg_next = CRC_ONES;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_DATA;
      lead_cnt   <= '0;
      lead_done  <= 1'b0;
      leader_run <= '0;
      crc_reg    <= CRC_ONES;
      crc_idx    <= '0;
      esc_crc    <= 1'b0;
      esc_end    <= 1'b0;
      ovalid     <= 1'b0;
    end else begin
      if (fire) begin
        phase      <= phase_next;
        lead_cnt   <= lead_cnt_next;
        lead_done  <= lead_done_next;
        leader_run <= leader_run_next;
        crc_reg    <= crc_reg_next;
        crc_idx    <= crc_idx_next;
        esc_crc    <= esc_crc_next;
        esc_end    <= esc_end_next;
        ovalid     <= 1'b1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte     <= emit_b;
      end_of_frame <= emit_eof;
    end
  end

  a_lead_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LEAD) |-> (lead_cnt != 4'd0 && lead_cnt < cfg.lead_len))
    else $error("leader count out of range");

  a_pop_needs_word: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_frame_end_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && emit_eof) |=> (leader_run == 3'd0 && crc_reg == CRC_ONES && phase == PH_DATA))
    else $error("frame state not cleared after end of frame");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CRC-32 byte-stuffing framer. A directed table
// covers the leader, escape insertion, frame end on an escape, single byte
// packets, clamped leader lengths, unmapped register writes and a register
// change inside a packet. Random packets follow under several register
// settings and handshake idle patterns. Every output word is compared with
// a local model of the framer or with words given by hand in the table.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cbsf_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int PHASES = 8;
  localparam int PHASE_BYTES = 39;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd6;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [7:0]             data;
    logic                   lst;
    int                     n_fixed;
    logic [7:0]             w0;
    logic [7:0]             w1;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } frame_word_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic [7:0]           in_byte = '0;
  logic                 last = 1'b0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [7:0]           out_byte;
  logic                 end_of_frame;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  // framer model state and registers
  logic [7:0]  ldr_byte = 8'd60;
  logic [3:0]  ldr_len = 4'd4;
  logic [7:0]  esc_byte = 8'd195;
  logic        crc_on = 1'b1;
  logic        pkt_open = 1'b0;
  logic [2:0]  ldr_run = '0;
  logic [31:0] crc_acc = CRC_ONES;

  frame_word_t byte_words[$];
  frame_word_t frame_words[$];
  stim_row_t   dir_tab[$];

  int send_idle = 0;
  int recv_stall = 0;
  int mismatches = 0;
  int cycles = 0;

  crc32_byte_stuffing_framer_core dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .in_byte      (in_byte),
    .last         (last),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .end_of_frame (end_of_frame),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("crc32_byte_stuffing_framer_core regression: fail");
      $finish;
    end
  end

  function automatic int leader_count();
    if (ldr_len < 4'd2) return 2;
    if (ldr_len > 4'd8) return 8;
    return int'(ldr_len);
  endfunction

  function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    r = c ^ {24'd0, d};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY_REFL) : (r >> 1);
    end
    return r;
  endfunction

  task automatic emit_stuffed(input logic [7:0] b);
    byte_words.push_back({b, 1'b0});
    if (b == ldr_byte) begin
      ldr_run = ldr_run + 3'd1;
    end else begin
      ldr_run = '0;
    end
    if (int'(ldr_run) == leader_count() - 1) begin
      byte_words.push_back({esc_byte, 1'b0});
      ldr_run = '0;
    end
  endtask

  // words produced by one input byte, left in byte_words
  task automatic frame_one_byte(input logic [7:0] b, input logic l);
    logic [31:0] fcs;
    frame_word_t w;
    byte_words.delete();
    if (!pkt_open) begin
      for (int n = 0; n < leader_count(); n++) begin
        byte_words.push_back({ldr_byte, 1'b0});
      end
      pkt_open = 1'b1;
      ldr_run = '0;
      crc_acc = CRC_ONES;
    end
    emit_stuffed(b);
    crc_acc = crc_next(crc_acc, b);
    if (l) begin
      if (crc_on) begin
        fcs = crc_acc ^ CRC_ONES;
        emit_stuffed(fcs[31:24]);
        emit_stuffed(fcs[23:16]);
        emit_stuffed(fcs[15:8]);
        emit_stuffed(fcs[7:0]);
      end
      w = byte_words.pop_back();
      w.eof = 1'b1;
      byte_words.push_back(w);
      pkt_open = 1'b0;
      ldr_run = '0;
      crc_acc = CRC_ONES;
    end
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] d);
    case (idx)
      REG_LEADER_BYTE: ldr_byte = d;
      REG_LEADER_LENGTH: ldr_len = d[3:0];
      REG_ESCAPE_BYTE: esc_byte = d;
      REG_CRC_ENABLE: crc_on = d[0];
      default: ;
    endcase
  endtask

  // n_fixed > 0: words given by hand, model output only advances its state
  task automatic send_byte(input logic [7:0] b, input logic l, input int n_fixed,
                           input logic [7:0] w0, input logic [7:0] w1);
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    last <= l;
    do @(posedge clk); while (full !== 1'b0);
    frame_one_byte(b, l);
    if (n_fixed == 0) begin
      foreach (byte_words[i]) frame_words.push_back(byte_words[i]);
    end else if (n_fixed == 1) begin
      frame_words.push_back({w0, l});
    end else begin
      frame_words.push_back({w0, 1'b0});
      frame_words.push_back({w1, l});
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (frame_words.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] d);
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    apply_reg(idx, d);
  endtask

  task automatic add_byte(input logic [7:0] b, input logic l, input int n,
                          input logic [7:0] w0, input logic [7:0] w1);
    stim_row_t r;
    r.kind = ROW_BYTE;
    r.idx = '0;
    r.data = b;
    r.lst = l;
    r.n_fixed = n;
    r.w0 = w0;
    r.w1 = w1;
    dir_tab.push_back(r);
  endtask

  task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] d);
    stim_row_t r;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = d;
    r.lst = 1'b0;
    r.n_fixed = 0;
    r.w0 = '0;
    r.w1 = '0;
    dir_tab.push_back(r);
  endtask

  // result side
  initial begin
    frame_word_t w;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (frame_words.size() == 0) begin
          $error("out_byte: no word pending, got 0x%02h end_of_frame %0b",
                 out_byte, end_of_frame);
          mismatches++;
        end else begin
          w = frame_words.pop_front();
          if (out_byte !== w.data) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", w.data, out_byte);
            mismatches++;
          end
          if (end_of_frame !== w.eof) begin
            $error("end_of_frame: expected %0b, got %0b", w.eof, end_of_frame);
            mismatches++;
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_stall);
    end
  end

  initial begin
    int pkt_left;
    int r;
    logic [7:0] b;

    // reset settings: leader 0x3C x4, escape 0xC3, CRC on
    add_byte(8'h00, 1'b0, 0, 8'h00, 8'h00);
    add_byte(8'hFF, 1'b0, 1, 8'hFF, 8'h00);
    add_byte(8'h3C, 1'b0, 1, 8'h3C, 8'h00);
    add_byte(8'h3C, 1'b0, 1, 8'h3C, 8'h00);
    add_byte(8'h3C, 1'b0, 2, 8'h3C, 8'hC3);
    add_byte(8'h3C, 1'b0, 1, 8'h3C, 8'h00);
    add_byte(8'h55, 1'b1, 0, 8'h00, 8'h00);
    // length 0 clamps to 2; single leader byte frame ends on the escape
    add_reg(REG_CRC_ENABLE, 8'h00);
    add_reg(REG_LEADER_LENGTH, 8'h00);
    add_byte(8'h3C, 1'b1, 0, 8'h00, 8'h00);
    add_byte(8'hA5, 1'b0, 0, 8'h00, 8'h00);
    add_byte(8'h5A, 1'b1, 1, 8'h5A, 8'h00);
    // length 15 clamps to 8
    add_reg(REG_LEADER_LENGTH, 8'h0F);
    add_reg(REG_LEADER_BYTE, 8'hFF);
    add_reg(REG_ESCAPE_BYTE, 8'h00);
    add_reg(REG_CRC_ENABLE, 8'h01);
    add_byte(8'hFF, 1'b0, 0, 8'h00, 8'h00);
    add_byte(8'hFF, 1'b0, 1, 8'hFF, 8'h00);
    add_byte(8'hFF, 1'b0, 1, 8'hFF, 8'h00);
    add_byte(8'hFF, 1'b0, 1, 8'hFF, 8'h00);
    add_byte(8'hFF, 1'b0, 1, 8'hFF, 8'h00);
    add_byte(8'hFF, 1'b0, 1, 8'hFF, 8'h00);
    add_byte(8'hFF, 1'b0, 2, 8'hFF, 8'h00);
    add_byte(8'hFF, 1'b1, 0, 8'h00, 8'h00);
    add_reg(REG_LEADER_LENGTH, 8'h01);
    add_reg(REG_LEADER_BYTE, 8'h00);
    add_reg(REG_ESCAPE_BYTE, 8'hFF);
    add_reg(REG_UNMAPPED, 8'hAA);
    add_byte(8'h00, 1'b1, 0, 8'h00, 8'h00);
    add_byte(8'h00, 1'b0, 0, 8'h00, 8'h00);
    // leader value changed inside a packet
    add_reg(REG_LEADER_BYTE, 8'h12);
    add_byte(8'h12, 1'b0, 2, 8'h12, 8'hFF);
    add_byte(8'h7E, 1'b1, 0, 8'h00, 8'h00);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        wait_drained();
        reg_write(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_byte(dir_tab[i].data, dir_tab[i].lst, dir_tab[i].n_fixed,
                  dir_tab[i].w0, dir_tab[i].w1);
      end
    end

    pkt_left = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 64; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 64; end
        default: begin send_idle = 25; recv_stall = 25; end
      endcase
      reg_write(REG_LEADER_BYTE, (ph == 0) ? 8'h00 :
                                 (ph == 1) ? 8'hFF : 8'($urandom_range(255)));
      reg_write(REG_LEADER_LENGTH, (ph == 0) ? 8'h02 :
                                   (ph == 1) ? 8'h08 : 8'($urandom_range(255)));
      reg_write(REG_ESCAPE_BYTE, 8'($urandom_range(255)));
      reg_write(REG_CRC_ENABLE, (ph < 2) ? 8'h01 : 8'($urandom_range(255)));
      if ($urandom_range(3) == 0) begin
        reg_write(REG_UNMAPPED, 8'($urandom_range(255)));
      end
      // packets may straddle a phase, so settings also change mid-packet
      for (int k = 0; k < PHASE_BYTES; k++) begin
        if (pkt_left == 0) begin
          pkt_left = ($urandom_range(7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
        end
        r = $urandom_range(9);
        if (r < 5) begin
          b = ldr_byte;
        end else if (r == 5) begin
          b = esc_byte;
        end else begin
          b = 8'($urandom_range(255));
        end
        pkt_left--;
        send_byte(b, pkt_left == 0, 0, 8'h00, 8'h00);
      end
    end
    if (pkt_left != 0) begin
      send_byte(8'($urandom_range(255)), 1'b1, 0, 8'h00, 8'h00);
    end

    wait_drained();
    recv_stall = 0;
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("crc32_byte_stuffing_framer_core regression: pass");
    end else begin
      $display("crc32_byte_stuffing_framer_core regression: fail");
    end
    $finish;
  end

endmodule
